### sv/thp_sensor_compensation_macros.svh
// Assertion macros shared by the sensor compensation RTL.
// Clock is clk and reset is rst_n in every module that uses them.
`ifndef THP_SENSOR_COMPENSATION_MACROS_SVH
`define THP_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, off during reset
`define THP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define THP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/thp_pkg.sv
// Shared types and constants for the sensor compensation block.
// Used by thp_div_pipe and thp_sensor_compensation; no dependencies.
package thp_pkg;

  localparam int DIV_W = 64;

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM     = 3'd4;

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  // Results carried alongside the pressure division
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               pres_ok;
  } thp_side_t;

endpackage

### sv/thp_sensor_compensation.sv
// Throughput: one transaction per cycle; the whole pipeline advances whenever the
// output register is empty or taken, so in_tready follows out_tready.
// The depth is set by the 64-stage quotient pipeline of the pressure division.
// Reset (synchronous, rst_n low) clears all valid bits and calibration registers.
`include "thp_sensor_compensation_macros.svh"
module thp_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // temperature_centi[31:0], humidity_q10[48:32], pressure_q8[80:49], zero fill
  output logic [87:0] out_tdata,
  // pressure_valid
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import thp_pkg::*;

  // ---------------- configuration registers ----------------
  logic [47:0] temp_calib_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  logic [63:0] hum_calib_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
      hum_calib_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        REG_TEMP:    temp_calib_r <= cfg_pwdata[47:0];
        REG_PRESS_A: press_a_r    <= cfg_pwdata;
        REG_PRESS_B: press_b_r    <= cfg_pwdata;
        REG_PRESS_C: press_c_r    <= cfg_pwdata[15:0];
        REG_HUM:     hum_calib_r  <= cfg_pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_TEMP:    cfg_prdata = {16'b0, temp_calib_r};
      REG_PRESS_A: cfg_prdata = press_a_r;
      REG_PRESS_B: cfg_prdata = press_b_r;
      REG_PRESS_C: cfg_prdata = {48'b0, press_c_r};
      REG_HUM:     cfg_prdata = hum_calib_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- calibration words ----------------
  logic signed [31:0] t1x, t2x, t3x, h1x, h2x, h3x, h5x, h6x;
  logic [11:0]        h4;
  logic signed [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

  assign t1x = $signed({16'b0, temp_calib_r[15:0]});
  assign t2x = $signed({{16{temp_calib_r[31]}}, temp_calib_r[31:16]});
  assign t3x = $signed({{16{temp_calib_r[47]}}, temp_calib_r[47:32]});
  assign h1x = $signed({24'b0, hum_calib_r[7:0]});
  assign h2x = $signed({{16{hum_calib_r[23]}}, hum_calib_r[23:8]});
  assign h3x = $signed({24'b0, hum_calib_r[31:24]});
  assign h4  = hum_calib_r[43:32];
  assign h5x = $signed({20'b0, hum_calib_r[55:44]});
  assign h6x = $signed({{24{hum_calib_r[63]}}, hum_calib_r[63:56]});
  assign p1x = $signed({48'b0, press_a_r[15:0]});
  assign p2x = $signed({{48{press_a_r[31]}}, press_a_r[31:16]});
  assign p3x = $signed({{48{press_a_r[47]}}, press_a_r[47:32]});
  assign p4x = $signed({{48{press_a_r[63]}}, press_a_r[63:48]});
  assign p5x = $signed({{48{press_b_r[15]}}, press_b_r[15:0]});
  assign p6x = $signed({{48{press_b_r[31]}}, press_b_r[31:16]});
  assign p7x = $signed({{48{press_b_r[47]}}, press_b_r[47:32]});
  assign p8x = $signed({{48{press_b_r[63]}}, press_b_r[63:48]});
  assign p9x = $signed({{48{press_c_r[15]}}, press_c_r});

  // ---------------- pipeline control ----------------
  logic        pipe_en;
  logic [15:1] s_vld_r;
  logic [5:1]  d_vld_r;
  logic        out_vld_r;
  logic        div_vld;

  assign pipe_en   = ~out_vld_r | out_tready;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r   <= '0;
      d_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s_vld_r   <= {s_vld_r[14:1], in_tvalid};
      d_vld_r   <= {d_vld_r[4:1], div_vld};
      out_vld_r <= d_vld_r[5];
    end
  end

  // ---------------- front stages: temperature, humidity, pressure operands ----------------
  logic [19:0]        s1_adcp_r, s2_adcp_r, s3_adcp_r, s4_adcp_r, s5_adcp_r, s6_adcp_r;
  logic [19:0]        s7_adcp_r, s8_adcp_r;
  logic [15:0]        s1_adch_r, s2_adch_r, s3_adch_r, s4_adch_r;
  logic signed [31:0] s1_a1_r, s1_d_r, s2_am_r, s2_dd_r, s3_a_r, s3_bm_r, s4_fine_r;
  logic signed [31:0] s5_tm_r, s5_v_r, s5_x0_r;
  logic signed [32:0] s5_e1_r;
  logic signed [63:0] e1x;
  logic signed [31:0] s6_hx_r, s6_hy1_r, s6_hy2_r;
  logic signed [63:0] s6_ee_r, s6_ep5_r, s6_ep2_r;
  logic signed [31:0] s7_x_r, s7_y1_r, s7_y2_r;
  logic signed [63:0] s7_e2a_r, s7_f1a_r, s7_ep5_r, s7_ep2_r;
  logic signed [31:0] s8_y3_r, s8_x_r, s9_x_r, s10_x_r, s11_x_r;
  logic signed [63:0] s8_e2_r, s8_f1b_r;
  logic signed [31:0] s9_y4_r, s10_y5_r, s11_y_r;
  logic signed [63:0] s9_f1c_r, s9_num0_r, s10_f1d_r, s10_num_r;
  logic signed [63:0] s11_f1_r, s11_num_r, s12_f1_r, s12_num_r;
  logic signed [63:0] s13_f1_r, s13_num_r, s14_f1_r, s14_num_r, s15_f1_r, s15_num_r;
  logic signed [31:0] s12_hv_r, s13_hv_r, s13_sq0_r, s14_hv_r, s14_sqh_r;
  logic signed [31:0] s6_t_r, s7_t_r, s8_t_r, s9_t_r, s10_t_r, s11_t_r, s12_t_r;
  logic signed [31:0] s13_t_r, s14_t_r, s15_t_r;
  logic [16:0]        s15_hum_r;
  logic [20:0]        pm;
  logic signed [31:0] s12_h15, hv_fin;

  assign e1x     = {{31{s5_e1_r[32]}}, s5_e1_r};
  assign pm      = 21'h100000 - {1'b0, s8_adcp_r};
  assign s12_h15 = s12_hv_r >>> 15;
  assign hv_fin  = s14_hv_r - (s14_sqh_r >>> 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // S1: offsets from T1
      s1_a1_r   <= $signed({15'b0, in_tdata[19:3]}) - $signed({15'b0, temp_calib_r[15:0], 1'b0});
      s1_d_r    <= $signed({16'b0, in_tdata[19:4]}) - t1x;
      s1_adcp_r <= in_tdata[39:20];
      s1_adch_r <= in_tdata[55:40];
      // S2: products with T2 and the square term
      s2_am_r   <= s1_a1_r * t2x;
      s2_dd_r   <= s1_d_r * s1_d_r;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
      // S3
      s3_a_r    <= s2_am_r >>> 11;
      s3_bm_r   <= (s2_dd_r >>> 12) * t3x;
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;
      // S4: fine temperature
      s4_fine_r <= s3_a_r + (s3_bm_r >>> 14);
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
      // S5: fan out from fine temperature; humidity offset from H4
      s5_tm_r   <= s4_fine_r * 32'sd5 + 32'sd128;
      s5_v_r    <= s4_fine_r - 32'sd76800;
      s5_e1_r   <= {s4_fine_r[31], s4_fine_r} - 33'sd128000;
      s5_x0_r   <= $signed({2'b0, s4_adch_r, 14'b0}) - $signed({h4, 20'b0});
      s5_adcp_r <= s4_adcp_r;
      // S6
      s6_t_r    <= s5_tm_r >>> 8;
      s6_hx_r   <= s5_x0_r - h5x * s5_v_r;
      s6_hy1_r  <= s5_v_r * h3x;
      s6_hy2_r  <= s5_v_r * h6x;
      s6_ee_r   <= e1x * e1x;
      s6_ep5_r  <= e1x * p5x;
      s6_ep2_r  <= e1x * p2x;
      s6_adcp_r <= s5_adcp_r;
      // S7
      s7_t_r    <= s6_t_r;
      s7_x_r    <= (s6_hx_r + 32'sd16384) >>> 15;
      s7_y1_r   <= (s6_hy1_r >>> 11) + 32'sd32768;
      s7_y2_r   <= s6_hy2_r >>> 10;
      s7_e2a_r  <= s6_ee_r * p6x;
      s7_f1a_r  <= s6_ee_r * p3x;
      s7_ep5_r  <= s6_ep5_r;
      s7_ep2_r  <= s6_ep2_r;
      s7_adcp_r <= s6_adcp_r;
      // S8
      s8_t_r    <= s7_t_r;
      s8_x_r    <= s7_x_r;
      s8_y3_r   <= s7_y2_r * s7_y1_r;
      s8_e2_r   <= s7_e2a_r + (s7_ep5_r <<< 17) + (p4x <<< 35);
      s8_f1b_r  <= (s7_f1a_r >>> 8) + (s7_ep2_r <<< 12);
      s8_adcp_r <= s7_adcp_r;
      // S9
      s9_t_r    <= s8_t_r;
      s9_x_r    <= s8_x_r;
      s9_y4_r   <= (s8_y3_r >>> 10) + 32'sd2097152;
      s9_f1c_r  <= 64'sh0000_8000_0000_0000 + s8_f1b_r;
      s9_num0_r <= $signed({12'b0, pm, 31'b0}) - s8_e2_r;
      // S10
      s10_t_r   <= s9_t_r;
      s10_x_r   <= s9_x_r;
      s10_y5_r  <= s9_y4_r * h2x;
      s10_f1d_r <= s9_f1c_r * p1x;
      s10_num_r <= s9_num0_r * 64'sd3125;
      // S11
      s11_t_r   <= s10_t_r;
      s11_x_r   <= s10_x_r;
      s11_y_r   <= (s10_y5_r + 32'sd8192) >>> 14;
      s11_f1_r  <= s10_f1d_r >>> 33;
      s11_num_r <= s10_num_r;
      // S12
      s12_t_r   <= s11_t_r;
      s12_hv_r  <= s11_x_r * s11_y_r;
      s12_f1_r  <= s11_f1_r;
      s12_num_r <= s11_num_r;
      // S13
      s13_t_r   <= s12_t_r;
      s13_hv_r  <= s12_hv_r;
      s13_sq0_r <= s12_h15 * s12_h15;
      s13_f1_r  <= s12_f1_r;
      s13_num_r <= s12_num_r;
      // S14
      s14_t_r   <= s13_t_r;
      s14_hv_r  <= s13_hv_r;
      s14_sqh_r <= (s13_sq0_r >>> 7) * h1x;
      s14_f1_r  <= s13_f1_r;
      s14_num_r <= s13_num_r;
      // S15: clamp humidity to 0..100 %RH
      s15_t_r   <= s14_t_r;
      if (hv_fin[31]) begin
        s15_hum_r <= '0;
      end else if (hv_fin > HUM_MAX) begin
        s15_hum_r <= HUM_MAX[28:12];
      end else begin
        s15_hum_r <= hv_fin[28:12];
      end
      s15_f1_r  <= s14_f1_r;
      s15_num_r <= s14_num_r;
    end
  end

  // ---------------- pressure division ----------------
  thp_side_t          div_side_in;
  thp_side_t          div_side;
  logic signed [63:0] div_q;

  assign div_side_in.temp    = s15_t_r;
  assign div_side_in.hum     = s15_hum_r;
  assign div_side_in.pres_ok = (s15_f1_r != 64'sd0);

  thp_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (s_vld_r[15]),
    .numer    (s15_num_r),
    .denom    (s15_f1_r),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .quot     (div_q),
    .out_side (div_side)
  );

  // ---------------- back stages: pressure correction and saturation ----------------
  thp_side_t          d1_side_r, d2_side_r, d3_side_r, d4_side_r, d5_side_r;
  logic signed [63:0] d1_p_r, d1_ps_r, d1_g1a_r, d1_g2a_r;
  logic signed [63:0] d2_p_r, d2_g2a_r, d3_p_r, d3_g2a_r, d3_g1b_r, d4_sum_r, d5_pf_r;
  logic [63:0]        d2_ll_r;
  logic [31:0]        d2_cr_r;
  logic [31:0]        out_temp_r;
  logic [16:0]        out_hum_r;
  logic [31:0]        out_pres_r;
  logic               out_pv_r;
  logic signed [63:0] div_qs;

  assign div_qs = div_q >>> 13;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // D1
      d1_side_r <= div_side;
      d1_p_r    <= div_q;
      d1_ps_r   <= div_qs;
      d1_g1a_r  <= p9x * div_qs;
      d1_g2a_r  <= p8x * div_q;
      // D2: wrapped 64-bit product from 32-bit partial products
      d2_side_r <= d1_side_r;
      d2_p_r    <= d1_p_r;
      d2_g2a_r  <= d1_g2a_r;
      d2_ll_r   <= {32'b0, d1_g1a_r[31:0]} * {32'b0, d1_ps_r[31:0]};
      d2_cr_r   <= d1_g1a_r[63:32] * d1_ps_r[31:0] + d1_g1a_r[31:0] * d1_ps_r[63:32];
      // D3
      d3_side_r <= d2_side_r;
      d3_p_r    <= d2_p_r;
      d3_g2a_r  <= d2_g2a_r;
      d3_g1b_r  <= $signed(d2_ll_r + {d2_cr_r, 32'b0});
      // D4
      d4_side_r <= d3_side_r;
      d4_sum_r  <= d3_p_r + (d3_g1b_r >>> 25) + (d3_g2a_r >>> 19);
      // D5
      d5_side_r <= d4_side_r;
      d5_pf_r   <= (d4_sum_r >>> 8) + (p7x <<< 4);
      // Output register: drop pressure on a zero divisor, saturate to 32 bits
      out_temp_r <= d5_side_r.temp;
      out_hum_r  <= d5_side_r.hum;
      out_pv_r   <= d5_side_r.pres_ok;
      if (!d5_side_r.pres_ok || d5_pf_r[63]) begin
        out_pres_r <= '0;
      end else if (d5_pf_r[62:32] != '0) begin
        out_pres_r <= '1;
      end else begin
        out_pres_r <= d5_pf_r[31:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_pres_r, out_hum_r, out_temp_r};
  assign out_tuser  = out_pv_r;

  `THP_ASSERT_IMP(a_pres_zero_bad_div, out_vld_r && !out_pv_r, out_pres_r == '0, "stray pressure")
  `THP_ASSERT_IMP(a_hum_range, out_vld_r, out_hum_r <= 17'd102400, "humidity above 100 percent")
  `THP_ASSERT_NXT(a_div_entry_hold, s_vld_r[15] && !pipe_en, s_vld_r[15], "entry lost in stall")

endmodule

### sv/thp_div_pipe.sv
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Carries a side record with each transaction. Depends on thp_pkg.
module thp_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [63:0]  numer,
  input  logic signed [63:0]  denom,
  input  thp_pkg::thp_side_t  in_side,
  output logic                out_vld,
  output logic signed [63:0]  quot,
  output thp_pkg::thp_side_t  out_side
);
  import thp_pkg::*;

  logic             vld_r  [DIV_W+1];
  logic [DIV_W-1:0] rem_r  [DIV_W+1];
  logic [DIV_W-1:0] qd_r   [DIV_W+1];
  logic [DIV_W-1:0] dv_r   [DIV_W+1];
  logic             neg_r  [DIV_W+1];
  thp_side_t        side_r [DIV_W+1];

  logic               out_vld_r;
  logic signed [63:0] quot_r;
  thp_side_t          out_side_r;

  // Take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      qd_r[0]   <= numer[DIV_W-1] ? $unsigned(-numer) : $unsigned(numer);
      dv_r[0]   <= denom[DIV_W-1] ? $unsigned(-denom) : $unsigned(denom);
      neg_r[0]  <= numer[DIV_W-1] ^ denom[DIV_W-1];
      side_r[0] <= in_side;
    end
  end

  // One restoring step per stage
  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic [DIV_W:0] sh;
    logic [DIV_W:0] diff;
    logic           ge;

    assign sh   = {rem_r[k], qd_r[k][DIV_W-1]};
    assign diff = sh - {1'b0, dv_r[k]};
    assign ge   = ~diff[DIV_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
        qd_r[k+1]   <= {qd_r[k][DIV_W-2:0], ge};
        dv_r[k+1]   <= dv_r[k];
        neg_r[k+1]  <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r     <= neg_r[DIV_W] ? -$signed(qd_r[DIV_W]) : $signed(qd_r[DIV_W]);
      out_side_r <= side_r[DIV_W];
    end
  end

  assign out_vld  = out_vld_r;
  assign quot     = quot_r;
  assign out_side = out_side_r;

endmodule

### dv/tb_top.sv
// Testbench for thp_sensor_compensation: drives raw samples, checks every result
// against a built-in compensation predictor. Depends on thp_pkg and the block RTL.
module tb_top;
  import thp_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int         DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic [31:0]        pres;
    logic               pres_ok;
  } comp_result_t;

  logic        clk;
  logic        rst_n;
  logic [55:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Calibration as the predictor sees it
  logic [63:0] cal_temp, cal_pa, cal_pb, cal_pc, cal_hum;

  comp_result_t result_q[$];
  int           errors;
  int           hold_cycles;
  bit           idle_on;

  thp_sensor_compensation dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Signed 64-bit division truncating toward zero; quotient wraps
  function automatic logic signed [63:0] div_trunc(logic signed [63:0] n,
                                                   logic signed [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] rt, logic [19:0] rp,
                                              logic [15:0] rh);
    logic signed [31:0] adc_t, adc_h, t1, t2, t3, a, d, b, fine, v, x, y, sq;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    logic signed [63:0] fine64, adc_p, e1, e2, f1, p, g1, g2;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    comp_result_t r;
    adc_t = {12'd0, rt};
    adc_h = {16'd0, rh};
    adc_p = {44'd0, rp};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {20'd0, cal_hum[43:32]};
    h5 = {20'd0, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
    p1 = {48'd0, cal_pa[15:0]};
    p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
    p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
    p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
    p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
    p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
    p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
    p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
    p9 = {{48{cal_pc[15]}}, cal_pc[15:0]};

    // fine temperature and temperature
    a = ((adc_t >>> 3) - (t1 <<< 1)) * t2;
    a = a >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    r.temp = (fine * 5 + 128) >>> 8;

    // humidity, clamped before the final shift
    v = fine - 76800;
    x = (adc_h <<< 14) - (h4 <<< 20) - (h5 * v);
    x = (x + 16384) >>> 15;
    y = ((v * h3) >>> 11) + 32768;
    y = (((v * h6) >>> 10) * y) >>> 10;
    y = (((y + 2097152) * h2) + 8192) >>> 14;
    v = x * y;
    sq = ((v >>> 15) * (v >>> 15)) >>> 7;
    v = v - ((sq * h1) >>> 4);
    if (v < 0) v = 0;
    if (v > HUM_MAX) v = HUM_MAX;
    r.hum = 17'(v >>> 12);

    // pressure through the 64-bit division
    fine64 = fine;
    e1 = fine64 - 64'sd128000;
    e2 = e1 * e1 * p6 + ((e1 * p5) <<< 17) + (p4 <<< 35);
    f1 = ((e1 * e1 * p3) >>> 8) + ((e1 * p2) <<< 12);
    f1 = (((64'sd1 <<< 47) + f1) * p1) >>> 33;
    r.pres = '0;
    r.pres_ok = 1'b0;
    if (f1 != 0) begin
      p = 64'sd1048576 - adc_p;
      p = div_trunc(((p <<< 31) - e2) * 64'sd3125, f1);
      g1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
      g2 = (p8 * p) >>> 19;
      p = ((p + g1 + g2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pres = '0;
      else if (p > 64'sh00000000FFFFFFFF) r.pres = 32'hFFFFFFFF;
      else r.pres = p[31:0];
      r.pres_ok = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one raw sample; hold tvalid high across back-to-back transactions
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    if (idle_on && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rh, rp, rt};
    do @(posedge clk); while (!in_tready);
    result_q.push_back(compensate(rt, rp, rh));
  endtask

  task automatic send_random();
    logic [19:0] rt, rp;
    logic [15:0] rh;
    if ($urandom_range(3) == 0) begin
      rt = 20'($urandom);
      rp = 20'($urandom);
      rh = 16'($urandom);
    end else begin
      rt = 20'($urandom_range(400000, 620000));
      rp = 20'($urandom_range(250000, 450000));
      rh = 16'($urandom_range(20000, 40000));
    end
    send_sample(rt, rp, rh);
  endtask

  // Drop tvalid and wait until the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_TEMP:    cal_temp = value & 64'hFFFF_FFFF_FFFF;
      REG_PRESS_A: cal_pa = value;
      REG_PRESS_B: cal_pb = value;
      REG_PRESS_C: cal_pc = value & 64'hFFFF;
      REG_HUM:     cal_hum = value;
      default: ;
    endcase
    // idle so the next write starts in a later time step
    @(posedge clk);
  endtask

  task automatic load_typical();
    write_reg(REG_TEMP, 64'h0000_FC18_6743_6B70);
    write_reg(REG_PRESS_A, 64'h0B27_0BD0_D643_8E7D);
    write_reg(REG_PRESS_B, 64'hC6F8_3C8C_FFF9_008C);
    write_reg(REG_PRESS_C, 64'h1770);
    write_reg(REG_HUM, 64'h1E03_2144_0001_6A4B);
  endtask

  task automatic send_corners();
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample('0, '1, '1);
    send_sample('1, '0, '0);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd519888, 20'd415148, 16'd0);
    send_sample(20'd519888, 20'd415148, 16'hFFFF);
  endtask

  // Reset calibration gives a zero divisor
  task automatic test_reset_calibration();
    send_corners();
    drain();
  endtask

  task automatic test_typical_calibration();
    load_typical();
    send_corners();
    drain();
  endtask

  // Extreme calibration words: saturation, clamping and wrap
  task automatic test_extreme_calibration();
    write_reg(REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_A, 64'h7FFF_8000_7FFF_FFFF);
    write_reg(REG_PRESS_B, 64'h8000_7FFF_8000_7FFF);
    write_reg(REG_PRESS_C, 64'h8000);
    write_reg(REG_HUM, 64'h80FF_FFFF_FF7F_FFFF);
    send_corners();
    drain();
    write_reg(REG_TEMP, 64'h7FFF_8000_0000);
    write_reg(REG_PRESS_A, 64'h8000_7FFF_8000_0001);
    write_reg(REG_PRESS_B, '1);
    write_reg(REG_PRESS_C, 64'h7FFF);
    write_reg(REG_HUM, 64'h7F00_0000_0080_0000);
    send_corners();
    drain();
  endtask

  // A write past the last register must change nothing
  task automatic test_unused_address();
    load_typical();
    write_reg(REG_UNUSED, '1);
    send_corners();
    drain();
  endtask

  // Stall the output long enough to back up the pipeline
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (150) send_random();
    drain();
  endtask

  task automatic test_random(int n);
    for (int s = 0; s < 6; s++) begin
      if (s == 0) load_typical();
      else begin
        write_reg(REG_TEMP, {$urandom, $urandom});
        write_reg(REG_PRESS_A, {$urandom, $urandom});
        write_reg(REG_PRESS_B, {$urandom, $urandom});
        write_reg(REG_PRESS_C, {$urandom, $urandom});
        write_reg(REG_HUM, {$urandom, $urandom});
      end
      // no idling on one phase
      idle_on = (s != 2);
      repeat (n) send_random();
      drain();
    end
    idle_on = 1'b1;
  endtask

  // Result channel ready, with random stalls and the long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= idle_on ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    comp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], '0);
      end else begin
        want = result_q.pop_front();
        if (out_tdata[31:0] !== want.temp)
          report_mismatch("temperature_centi", out_tdata[31:0], want.temp);
        if (out_tdata[48:32] !== want.hum)
          report_mismatch("humidity_q10", out_tdata[48:32], want.hum);
        if (out_tdata[80:49] !== want.pres)
          report_mismatch("pressure_q8", out_tdata[80:49], want.pres);
        if (out_tuser !== want.pres_ok)
          report_mismatch("pressure_valid", out_tuser, want.pres_ok);
      end
    end
  end

  initial begin
    errors = 0;
    hold_cycles = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cal_temp = '0;
    cal_pa = '0;
    cal_pb = '0;
    cal_pc = '0;
    cal_hum = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_typical_calibration();
    test_extreme_calibration();
    test_unused_address();
    test_backpressure();
    test_random(105);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
